[src/assert_macros.svh]
// Assertion helpers shared by the RTL. Both sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define BLCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BLCA_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/blca_pkg.sv]
`timescale 1ns / 1ps

package blca_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int JUMP_LEVELS = 10;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int K_W     = 10;
  localparam int DIST_W  = 11;

  localparam int NIDX_W   = $clog2(MAX_NODES);
  localparam int LVL_W    = $clog2(JUMP_LEVELS);
  localparam int JT_DEPTH = MAX_NODES * JUMP_LEVELS;
  localparam int JT_AW    = $clog2(JT_DEPTH);

  localparam int S_TDATA_W = ((2 * NODE_W + K_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((NODE_W + DIST_W + 7) / 8) * 8;

  localparam logic [LVL_W-1:0]   TOP_LVL   = LVL_W'(JUMP_LEVELS - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_LCA  = 2'd1,
    REQ_KTH  = 2'd2
  } req_t;

  // Store access for one cycle: two reads on each memory, one write each.
  typedef struct packed {
    logic [NODE_W-1:0]  info_ra0;
    logic [NODE_W-1:0]  info_ra1;
    logic [NODE_W-1:0]  jt_ra0_node;
    logic [LVL_W-1:0]   jt_ra0_lvl;
    logic [NODE_W-1:0]  jt_ra1_node;
    logic [LVL_W-1:0]   jt_ra1_lvl;
    logic               info_we;
    logic [NODE_W-1:0]  info_wa;
    logic [DEPTH_W-1:0] info_wd;
    logic               jt_we;
    logic [NODE_W-1:0]  jt_wa_node;
    logic [LVL_W-1:0]   jt_wa_lvl;
    logic [NODE_W-1:0]  jt_wd;
  } store_req_t;

  // Registered read data, valid in the cycle after the address.
  typedef struct packed {
    logic               mark0;
    logic [DEPTH_W-1:0] depth0;
    logic               mark1;
    logic [DEPTH_W-1:0] depth1;
    logic [NODE_W-1:0]  jt0;
    logic [NODE_W-1:0]  jt1;
  } store_rsp_t;

  // Highest jump level not above the remaining climb, capped at the top level.
  function automatic logic [LVL_W-1:0] lift_level(input logic [K_W-1:0] k);
    logic [LVL_W-1:0] lv;
    lv = '0;
    for (int i = 0; i < K_W; i++) begin
      if (k[i]) begin
        lv = (i >= JUMP_LEVELS - 1) ? TOP_LVL : LVL_W'(i);
      end
    end
    return lv;
  endfunction

endpackage

[src/binary_lifting_lca_engine.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload (lowest bit first)
// s_*      in   s_tvalid/s_tready  tdata: node_a[9:0] node_b[19:10] step_count[29:20]
//                                  tuser: req_type[1:0]
// m_*      out  m_tvalid/m_tready  tdata: result_node[9:0] path_distance[20:10]
//                                  tuser: error
// Per item: a rejected item goes straight to done; load writes one ancestor level
//   per read/write pair above level 0; k-th climbs one jump per set bit of k, none past
//   the root; lca lifts the deeper node, then, unless one is the other's ancestor, hops at
//   the top level, descends level by level and takes the parent, then reads its depth.
// Reset: sweep of all 1024 node info entries before s_tready rises.
// One item at a time; a finished item waits until m_tready frees the output register.
`include "assert_macros.svh"

module binary_lifting_lca_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [blca_pkg::S_TDATA_W-1:0]   s_tdata,  // node_a, node_b, step_count
  input  logic [1:0]                       s_tuser,  // req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [blca_pkg::M_TDATA_W-1:0]   m_tdata,  // result_node, path_distance
  output logic                             m_tuser   // error
);

  typedef enum logic [14:0] {
    ST_IDLE      = 15'b000000000000001,
    ST_CHECK     = 15'b000000000000010,
    ST_LOAD_RD   = 15'b000000000000100,
    ST_LOAD_USE  = 15'b000000000001000,
    ST_CLIMB_RD  = 15'b000000000010000,
    ST_CLIMB_USE = 15'b000000000100000,
    ST_TOP_RD    = 15'b000000001000000,
    ST_TOP_USE   = 15'b000000010000000,
    ST_DESC_RD   = 15'b000000100000000,
    ST_DESC_USE  = 15'b000001000000000,
    ST_PAR_RD    = 15'b000010000000000,
    ST_PAR_USE   = 15'b000100000000000,
    ST_DEP_RD    = 15'b001000000000000,
    ST_DEP_USE   = 15'b010000000000000,
    ST_DONE      = 15'b100000000000000
  } state_t;

  localparam int NW = blca_pkg::NODE_W;
  localparam int DW = blca_pkg::DEPTH_W;
  localparam int KW = blca_pkg::K_W;
  localparam int LW = blca_pkg::LVL_W;

  state_t state, state_next;

  // working registers; v doubles as the climb cursor and as the load walker
  logic [1:0]                  op, op_next;
  logic [NW-1:0]               a, a_next, b, b_next;
  logic [NW-1:0]               u, u_next, v, v_next;
  logic [DW-1:0]               da, da_next, db, db_next;
  logic [KW-1:0]               k_rem, k_rem_next;
  logic [LW-1:0]               lvl, lvl_next;
  logic [NW-1:0]               res, res_next;
  logic [blca_pkg::DIST_W-1:0] path_dist, path_dist_next;
  logic                        err, err_next;

  blca_pkg::store_req_t sreq;
  blca_pkg::store_rsp_t srsp;
  logic                 store_ready;

  logic          a_loaded, b_loaded, a_in_range, out_free;
  logic [LW-1:0] climb_lvl;
  logic [KW-1:0] climb_step;
  logic [DW+1:0] dist_full;

  blca_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (sreq),
    .rsp   (srsp),
    .ready (store_ready)
  );

  assign s_tready   = (state == ST_IDLE) && store_ready;
  assign out_free   = !m_tvalid || m_tready;
  assign a_in_range = int'(a) < blca_pkg::MAX_NODES;
  assign a_loaded   = a_in_range && srsp.mark0;
  assign b_loaded   = (int'(b) < blca_pkg::MAX_NODES) && srsp.mark1;

  // shared climb unit: biggest power-of-two jump that fits the remainder
  assign climb_lvl  = blca_pkg::lift_level(k_rem);
  assign climb_step = KW'(1) << climb_lvl;

  assign dist_full = {2'b00, da} + {2'b00, db} - {1'b0, srsp.depth0, 1'b0};

  always_comb begin
    state_next     = state;
    op_next        = op;
    a_next         = a;
    b_next         = b;
    u_next         = u;
    v_next         = v;
    da_next        = da;
    db_next        = db;
    k_rem_next     = k_rem;
    lvl_next       = lvl;
    res_next       = res;
    path_dist_next = path_dist;
    err_next       = err;

    sreq             = '0;
    sreq.info_ra0    = a;
    sreq.info_ra1    = b;
    sreq.jt_ra0_node = u;
    sreq.jt_ra0_lvl  = lvl;
    sreq.jt_ra1_node = v;
    sreq.jt_ra1_lvl  = lvl;

    case (state)
      ST_IDLE: begin
        // look up both nodes while the beat arrives
        sreq.info_ra0 = s_tdata[NW-1:0];
        sreq.info_ra1 = s_tdata[2*NW-1:NW];
        if (s_tvalid && s_tready) begin
          op_next        = s_tuser;
          a_next         = s_tdata[NW-1:0];
          b_next         = s_tdata[2*NW-1:NW];
          k_rem_next     = s_tdata[2*NW+KW-1:2*NW];
          res_next       = '0;
          path_dist_next = '0;
          err_next       = 1'b0;
          state_next     = ST_CHECK;
        end
      end

      ST_CHECK: begin
        case (op)
          blca_pkg::REQ_LOAD: begin
            if (a == '0 || !a_in_range || srsp.mark0 || !b_loaded ||
                srsp.depth1 >= blca_pkg::DEPTH_MAX) begin
              err_next   = 1'b1;
              state_next = ST_DONE;
            end else begin
              sreq.info_we    = 1'b1;
              sreq.info_wa    = a;
              sreq.info_wd    = srsp.depth1 + 1'b1;
              sreq.jt_we      = 1'b1;
              sreq.jt_wa_node = a;
              sreq.jt_wa_lvl  = '0;
              sreq.jt_wd      = b;
              v_next          = b;
              lvl_next        = LW'(1);
              state_next      = ST_LOAD_RD;
            end
          end
          blca_pkg::REQ_LCA: begin
            if (!a_loaded || !b_loaded) begin
              err_next   = 1'b1;
              state_next = ST_DONE;
            end else begin
              da_next = srsp.depth0;
              db_next = srsp.depth1;
              // u is the shallower node; v climbs to its depth
              if (srsp.depth0 > srsp.depth1) begin
                u_next     = b;
                v_next     = a;
                k_rem_next = KW'(srsp.depth0 - srsp.depth1);
              end else begin
                u_next     = a;
                v_next     = b;
                k_rem_next = KW'(srsp.depth1 - srsp.depth0);
              end
              // shallow side is the sentinel: the climb runs off the root
              if (srsp.depth0 == '0 || srsp.depth1 == '0) begin
                v_next     = '0;
                k_rem_next = '0;
              end
              state_next = ST_CLIMB_RD;
            end
          end
          blca_pkg::REQ_KTH: begin
            if (!a_loaded) begin
              err_next   = 1'b1;
              state_next = ST_DONE;
            end else if (k_rem >= KW'(srsp.depth0)) begin
              state_next = ST_DONE;
            end else begin
              v_next     = a;
              state_next = ST_CLIMB_RD;
            end
          end
          default: begin
            err_next   = 1'b1;
            state_next = ST_DONE;
          end
        endcase
      end

      ST_LOAD_RD: begin
        sreq.jt_ra0_node = v;
        sreq.jt_ra0_lvl  = lvl - LW'(1);
        state_next       = ST_LOAD_USE;
      end

      ST_LOAD_USE: begin
        sreq.jt_we      = 1'b1;
        sreq.jt_wa_node = a;
        sreq.jt_wa_lvl  = lvl;
        sreq.jt_wd      = srsp.jt0;
        v_next          = srsp.jt0;
        if (lvl == blca_pkg::TOP_LVL) begin
          state_next = ST_DONE;
        end else begin
          lvl_next   = lvl + LW'(1);
          state_next = ST_LOAD_RD;
        end
      end

      ST_CLIMB_RD: begin
        sreq.jt_ra0_node = v;
        sreq.jt_ra0_lvl  = climb_lvl;
        if (k_rem == '0) begin
          if (op == blca_pkg::REQ_KTH) begin
            res_next   = v;
            state_next = ST_DONE;
          end else if (u == v) begin
            res_next   = u;
            state_next = ST_DEP_RD;
          end else begin
            state_next = ST_TOP_RD;
          end
        end else begin
          state_next = ST_CLIMB_USE;
        end
      end

      ST_CLIMB_USE: begin
        v_next     = srsp.jt0;
        k_rem_next = k_rem - climb_step;
        state_next = ST_CLIMB_RD;
      end

      ST_TOP_RD: begin
        sreq.jt_ra0_lvl = blca_pkg::TOP_LVL;
        sreq.jt_ra1_lvl = blca_pkg::TOP_LVL;
        state_next      = ST_TOP_USE;
      end

      ST_TOP_USE: begin
        // keep hopping at the top level while the ancestors still differ
        if (srsp.jt0 != srsp.jt1) begin
          u_next     = srsp.jt0;
          v_next     = srsp.jt1;
          state_next = ST_TOP_RD;
        end else begin
          lvl_next   = blca_pkg::TOP_LVL - LW'(1);
          state_next = ST_DESC_RD;
        end
      end

      ST_DESC_RD: begin
        state_next = ST_DESC_USE;
      end

      ST_DESC_USE: begin
        if (srsp.jt0 != srsp.jt1) begin
          u_next = srsp.jt0;
          v_next = srsp.jt1;
        end
        if (lvl == '0) begin
          state_next = ST_PAR_RD;
        end else begin
          lvl_next   = lvl - LW'(1);
          state_next = ST_DESC_RD;
        end
      end

      ST_PAR_RD: begin
        sreq.jt_ra0_lvl = '0;
        state_next      = ST_PAR_USE;
      end

      ST_PAR_USE: begin
        res_next   = srsp.jt0;
        state_next = ST_DEP_RD;
      end

      ST_DEP_RD: begin
        sreq.info_ra0 = res;
        state_next    = ST_DEP_USE;
      end

      ST_DEP_USE: begin
        path_dist_next = blca_pkg::DIST_W'(dist_full);
        state_next     = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    a         <= a_next;
    b         <= b_next;
    u         <= u_next;
    v         <= v_next;
    da        <= da_next;
    db        <= db_next;
    k_rem     <= k_rem_next;
    lvl       <= lvl_next;
    res       <= res_next;
    path_dist <= path_dist_next;
    err       <= err_next;
    if (state == ST_DONE && out_free) begin
      m_tdata <= blca_pkg::M_TDATA_W'({path_dist, res});
      m_tuser <= err;
    end
  end

  `BLCA_ASSERT_NR(a_rst_blocks_input, rst |=> !s_tready, "input ready during reset sweep")
  `BLCA_ASSERT(a_one_item, (s_tvalid && s_tready) |=> !s_tready, "second beat taken while busy")
  `BLCA_ASSERT(a_out_from_done, $rose(m_tvalid) |-> $past(state == ST_DONE), "result without item")
  `BLCA_ASSERT(a_err_blank, (m_tvalid && m_tuser) |-> (m_tdata[blca_pkg::DIST_W+blca_pkg::NODE_W-1:0] == '0), "error beat carries data")
  `BLCA_ASSERT(a_climb_live, (state == ST_CLIMB_USE) |-> (k_rem != '0), "climb step with nothing left")

endmodule

[src/blca_store.sv]
`timescale 1ns / 1ps

// Ancestor table and node info (loaded mark + depth), with post-reset sweep.
module blca_store (
  input  logic                   clk,
  input  logic                   rst,
  input  blca_pkg::store_req_t   req,
  output blca_pkg::store_rsp_t   rsp,
  output logic                   ready
);

  logic [blca_pkg::DEPTH_W:0]  info_mem [blca_pkg::MAX_NODES];
  logic [blca_pkg::NODE_W-1:0] jt_mem   [blca_pkg::JT_DEPTH];

  logic                        clr_busy;
  logic [blca_pkg::NIDX_W-1:0] clr_cnt;

  function automatic logic [blca_pkg::JT_AW-1:0] jt_addr(
    input logic [blca_pkg::NODE_W-1:0] node,
    input logic [blca_pkg::LVL_W-1:0]  lvl
  );
    logic [blca_pkg::JT_AW-1:0] row;
    row = blca_pkg::JT_AW'(blca_pkg::NIDX_W'(node));
    return row * blca_pkg::JT_AW'(blca_pkg::JUMP_LEVELS) + blca_pkg::JT_AW'(lvl);
  endfunction

  assign ready = !clr_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      if (clr_cnt == blca_pkg::NIDX_W'(blca_pkg::MAX_NODES - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // sweep: node 0 marked at depth 0, every other node unmarked; row 0 zeroed
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      info_mem[clr_cnt] <= {(clr_cnt == '0), blca_pkg::DEPTH_W'(0)};
      if (blca_pkg::JT_AW'(clr_cnt) < blca_pkg::JT_AW'(blca_pkg::JUMP_LEVELS)) begin
        jt_mem[blca_pkg::JT_AW'(clr_cnt)] <= '0;
      end
    end else begin
      if (req.info_we) begin
        info_mem[blca_pkg::NIDX_W'(req.info_wa)] <= {1'b1, req.info_wd};
      end
      if (req.jt_we) begin
        jt_mem[jt_addr(req.jt_wa_node, req.jt_wa_lvl)] <= req.jt_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    {rsp.mark0, rsp.depth0} <= info_mem[blca_pkg::NIDX_W'(req.info_ra0)];
    {rsp.mark1, rsp.depth1} <= info_mem[blca_pkg::NIDX_W'(req.info_ra1)];
    rsp.jt0 <= jt_mem[jt_addr(req.jt_ra0_node, req.jt_ra0_lvl)];
    rsp.jt1 <= jt_mem[jt_addr(req.jt_ra1_node, req.jt_ra1_lvl)];
  end

endmodule
